@@ rtl/glpc_pkg.sv @@
package glpc_pkg;

  // Input item operations
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // Result kinds
  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_X           = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT_INDEX = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_INDEX  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPOSAL_RESTORE  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENCY_ON   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH      = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT     = 4'd7;
  localparam int CFG_DATA_W = 11;

  // Register reset values
  localparam logic [10:0] IMAGE_WIDTH_RST   = 11'd1;
  localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd240;

  // Line position saturates here
  localparam logic [10:0] POS_MAX = 11'd2047;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        operation;
    logic [7:0]  color_index;
    logic [15:0] palette_color;
    logic [9:0]  line_row;
    logic        line_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  window_x;
    logic [9:0]  window_y;
    logic [10:0] window_length;
    logic [15:0] pixel_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  frame_x;
    logic [10:0] image_width;
    logic [7:0]  transparent_index;
    logic [7:0]  background_index;
    logic        disposal_restore;
    logic        transparency_on;
    logic [10:0] screen_width;
    logic [10:0] screen_height;
  } cfg_t;

  // Command from front to back. start_x is frame_x for a direct window,
  // the pixel's own column for a buffered pixel, taken as run origin when it opens a run.
  typedef struct packed {
    logic        direct;
    logic        send_window;
    logic        append;
    logic        flush;
    logic [9:0]  start_x;
    logic [9:0]  row;
    logic [10:0] win_len;
    logic [15:0] color;
  } cmd_t;

endpackage

@@ rtl/gif_line_palette_compositor.sv @@
// Indexed-color line compositor: palette lookup to RGB565, cropping and
// transparent-run handling for one decoded image line at a time.
//
// Input side is a queue: drive item and push, the item is taken on a clock
// edge with push high and full low. An item either writes a palette slot
// (no result) or delivers one pixel. Result side is a queue too: while
// empty is low the oldest result sits on result; raise pop to take it.
// Results are window commands followed by pixel data; last marks the final
// result caused by one pixel item.
// Configuration goes through cfg_valid/cfg_ready (cfg_ready is always high),
// with cfg_index selecting the register; write only while the block is idle.
// For a direct pixel the back end takes the order and emits it, sending
// the line's window first when the pixel opens it; the sequencer handles
// one order at a time. A run flush emits its window and then its pixels,
// one buffer read per pixel.
// A 4-entry order queue lets the front keep accepting while the back
// flushes or the receiver stalls; full rises once it fills and another order waits.
// Reset (rst, synchronous) clears line position, runs, queues and restores
// the register reset values; palette contents are undefined until written.
module gif_line_palette_compositor
  import glpc_pkg::*;
#(
  parameter int RUN_BUFFER      = 32,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  in_item_t               item,
  output logic                   full,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  cmd_t q_out;
  logic q_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{frame_x: '0, image_width: IMAGE_WIDTH_RST, transparent_index: '0,
               background_index: '0, disposal_restore: 1'b0, transparency_on: 1'b0,
               screen_width: SCREEN_WIDTH_RST, screen_height: SCREEN_HEIGHT_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_X:           cfg.frame_x           <= cfg_data[9:0];
        REG_IMAGE_WIDTH:       cfg.image_width       <= cfg_data[10:0];
        REG_TRANSPARENT_INDEX: cfg.transparent_index <= cfg_data[7:0];
        REG_BACKGROUND_INDEX:  cfg.background_index  <= cfg_data[7:0];
        REG_DISPOSAL_RESTORE:  cfg.disposal_restore  <= cfg_data[0];
        REG_TRANSPARENCY_ON:   cfg.transparency_on   <= cfg_data[0];
        REG_SCREEN_WIDTH:      cfg.screen_width      <= cfg_data[10:0];
        REG_SCREEN_HEIGHT:     cfg.screen_height     <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  glpc_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  glpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  glpc_back #(
    .RUN_BUFFER(RUN_BUFFER)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_out),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  // Both sides come out of reset idle
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("block not idle after reset");

  // Pixel data is ready right after a window is taken
  a_window_then_pixel: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.kind == KIND_WINDOW) |=> !empty)
    else $error("no pixel data behind a window command");

  // A window never closes the results of an item and never covers zero pixels
  a_window_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_WINDOW) |-> (!result.last && result.window_length != 11'd0))
    else $error("malformed window command");

endmodule

@@ rtl/glpc_queue.sv @@
module glpc_queue
  import glpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t            slots [QUEUE_DEPTH];
  logic [AW:0]     wr_ptr;
  logic [AW:0]     rd_ptr;

  assign empty    = wr_ptr == rd_ptr;
  assign full     = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign pop_data = slots[rd_ptr[AW-1:0]];

  // Store pushed orders
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr[AW-1:0]] <= push_data;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

@@ rtl/glpc_front.sv @@
module glpc_front
  import glpc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     q_push,
  output cmd_t     q_data,
  input  logic     q_full
);

  localparam int PAW = $clog2(PALETTE_ENTRIES);

  logic [15:0]  palette [PALETTE_ENTRIES];
  logic [15:0]  pal_rd;

  logic [10:0]  line_position;
  logic         window_sent;
  logic         s1_valid;
  logic         s1_oor;
  cmd_t         s1_cmd;

  logic         accept;
  logic         is_pixel;
  logic [7:0]   idx_sub;
  logic         idx_ok;
  logic         trans;
  logic         is_transp;
  logic [11:0]  span;
  logic [10:0]  cut_width;
  logic         visible;
  logic         at_end;
  logic         direct;
  cmd_t         cmd_new;

  assign full     = s1_valid && q_full;
  assign accept   = push && !full;
  assign is_pixel = item.operation == OP_PIXEL;
  assign q_push   = s1_valid && !q_full;

  // Classify the incoming pixel
  always_comb begin
    idx_sub = (cfg.disposal_restore && item.color_index == cfg.transparent_index)
              ? cfg.background_index : item.color_index;
    idx_ok    = {1'b0, item.color_index} < 9'(PALETTE_ENTRIES);
    trans     = cfg.transparency_on && !cfg.disposal_restore;
    is_transp = idx_sub == cfg.transparent_index;
    span      = {2'b00, cfg.frame_x} + {1'b0, cfg.image_width};
    cut_width = (span > {1'b0, cfg.screen_width})
                ? 11'(cfg.screen_width - {1'b0, cfg.frame_x}) : cfg.image_width;
    visible   = ({1'b0, item.line_row} < cfg.screen_height) &&
                ({1'b0, cfg.frame_x} < cfg.screen_width) &&
                (cut_width != 11'd0) && (line_position < cut_width);
    at_end    = line_position == (cut_width - 11'd1);
    direct    = visible && !trans;

    cmd_new             = '0;
    cmd_new.direct      = direct;
    cmd_new.send_window = direct && !window_sent;
    cmd_new.append      = visible && trans && !is_transp;
    cmd_new.flush       = (visible && trans && (is_transp || at_end)) || item.line_end;
    cmd_new.start_x     = direct ? cfg.frame_x : cfg.frame_x + line_position[9:0];
    cmd_new.row         = item.line_row;
    cmd_new.win_len     = cut_width;
  end

  // Palette store: write on palette items, read on pixels
  always_ff @(posedge clk) begin
    if (accept && !is_pixel && idx_ok) begin
      palette[item.color_index[PAW-1:0]] <= item.palette_color;
    end
    if (accept && is_pixel) begin
      pal_rd <= palette[idx_sub[PAW-1:0]];
    end
  end

  // Hold the classified pixel until the queue takes it
  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      s1_cmd <= cmd_new;
      s1_oor <= !({1'b0, idx_sub} < 9'(PALETTE_ENTRIES));
    end
  end

  // Line state and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      line_position <= '0;
      window_sent   <= 1'b0;
    end else begin
      if (accept && is_pixel) begin
        s1_valid <= visible || item.line_end;
      end else if (q_push) begin
        s1_valid <= 1'b0;
      end
      if (accept && is_pixel) begin
        if (item.line_end) begin
          line_position <= '0;
          window_sent   <= 1'b0;
        end else begin
          if (line_position != POS_MAX) begin
            line_position <= line_position + 11'd1;
          end
          if (direct) begin
            window_sent <= 1'b1;
          end
        end
      end
    end
  end

  // Attach the palette color on the way to the queue
  always_comb begin
    q_data       = s1_cmd;
    q_data.color = s1_oor ? 16'd0 : pal_rd;
  end

endmodule

@@ rtl/glpc_back.sv @@
module glpc_back
  import glpc_pkg::*;
#(
  parameter int RUN_BUFFER = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  localparam int RB_AW = (RUN_BUFFER > 1) ? $clog2(RUN_BUFFER) : 1;
  localparam int RB_CW = $clog2(RUN_BUFFER + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DWIN = 3'd1;
  localparam logic [2:0] S_DPIX = 3'd2;
  localparam logic [2:0] S_FWIN = 3'd3;
  localparam logic [2:0] S_FPIX = 3'd4;

  logic [15:0]      run_mem [RUN_BUFFER];
  logic [15:0]      rd_data;

  logic [2:0]       state;
  logic [2:0]       state_next;
  cmd_t             cur;
  logic [RB_CW-1:0] run_count;
  logic [RB_CW-1:0] run_count_next;
  logic [9:0]       run_start_x;
  logic [RB_CW-1:0] fidx;
  logic [RB_CW-1:0] fidx_next;
  logic             out_valid;

  logic             can_load;
  logic             load;
  out_item_t        load_data;
  logic             rd_en;
  logic [RB_CW-1:0] rd_addr;
  logic [RB_CW-1:0] count_after;
  logic             flush_go;
  logic             f_last;

  assign empty    = !out_valid;
  assign can_load = !out_valid || pop;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  // Sequence the results of one order
  always_comb begin
    state_next     = state;
    run_count_next = run_count;
    fidx_next      = fidx;
    load           = 1'b0;
    load_data      = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    count_after    = q_data.append ? RB_CW'(run_count + 1'b1) : run_count;
    flush_go       = (q_data.flush || (q_data.append && count_after == RB_CW'(RUN_BUFFER)))
                     && (count_after != '0);
    f_last         = RB_CW'(fidx + 1'b1) == run_count;

    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          if (q_data.direct) begin
            run_count_next = '0;
            state_next     = q_data.send_window ? S_DWIN : S_DPIX;
          end else begin
            run_count_next = count_after;
            if (flush_go) begin
              state_next = S_FWIN;
            end
          end
        end
      end
      S_DWIN: begin
        load_data.kind          = KIND_WINDOW;
        load_data.window_x      = cur.start_x;
        load_data.window_y      = cur.row;
        load_data.window_length = cur.win_len;
        if (can_load) begin
          load       = 1'b1;
          state_next = S_DPIX;
        end
      end
      S_DPIX: begin
        load_data.kind        = KIND_PIXEL;
        load_data.pixel_color = cur.color;
        load_data.last        = 1'b1;
        if (can_load) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FWIN: begin
        load_data.kind          = KIND_WINDOW;
        load_data.window_x      = run_start_x;
        load_data.window_y      = cur.row;
        load_data.window_length = 11'(run_count);
        if (can_load) begin
          load       = 1'b1;
          rd_en      = 1'b1;
          fidx_next  = '0;
          state_next = S_FPIX;
        end
      end
      S_FPIX: begin
        load_data.kind        = KIND_PIXEL;
        load_data.pixel_color = rd_data;
        load_data.last        = f_last;
        if (can_load) begin
          load = 1'b1;
          if (f_last) begin
            run_count_next = '0;
            state_next     = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = RB_CW'(fidx + 1'b1);
            fidx_next = RB_CW'(fidx + 1'b1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Run buffer: append in order, read back during a flush
  always_ff @(posedge clk) begin
    if (q_pop && !q_data.direct && q_data.append) begin
      run_mem[run_count[RB_AW-1:0]] <= q_data.color;
    end
    if (rd_en) begin
      rd_data <= run_mem[rd_addr[RB_AW-1:0]];
    end
  end

  // Capture the order and load the result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (load) begin
      result <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      run_count   <= '0;
      run_start_x <= '0;
      fidx        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      run_count <= run_count_next;
      fidx      <= fidx_next;
      if (q_pop && !q_data.direct && q_data.append && run_count == '0) begin
        run_start_x <= q_data.start_x;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
module tb
  import glpc_pkg::*;
();

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int BURST_PIXELS  = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  in_item_t               item = '0;
  logic                   full;
  logic                   empty;
  logic                   pop = 1'b0;
  out_item_t              result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gif_line_palette_compositor dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Line compositor model plus the queue of draw items it still owes
  class draw_scoreboard;
    localparam int RUN_DEPTH     = 32;
    localparam int PALETTE_SLOTS = 256;

    cfg_t        regs;
    logic [15:0] palette [PALETTE_SLOTS];
    logic [15:0] run_pixels [RUN_DEPTH];
    int          run_len;
    logic [9:0]  run_x;
    int          line_pos;
    bit          window_open;
    int          emitted;
    out_item_t   expected_draws[$];
    int          mismatches;
    int          draws_checked;

    function new();
      regs = '0;
      regs.image_width = IMAGE_WIDTH_RST;
      regs.screen_width = SCREEN_WIDTH_RST;
      regs.screen_height = SCREEN_HEIGHT_RST;
      run_len = 0;
      run_x = '0;
      line_pos = 0;
      window_open = 1'b0;
      mismatches = 0;
      draws_checked = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_X:           regs.frame_x = val[9:0];
        REG_IMAGE_WIDTH:       regs.image_width = val;
        REG_TRANSPARENT_INDEX: regs.transparent_index = val[7:0];
        REG_BACKGROUND_INDEX:  regs.background_index = val[7:0];
        REG_DISPOSAL_RESTORE:  regs.disposal_restore = val[0];
        REG_TRANSPARENCY_ON:   regs.transparency_on = val[0];
        REG_SCREEN_WIDTH:      regs.screen_width = val;
        REG_SCREEN_HEIGHT:     regs.screen_height = val;
        default: ;
      endcase
    endfunction

    // Image width cut to what is left of the display right of the frame origin
    function int visible_width();
      int w;
      w = int'(regs.image_width);
      if (int'(regs.frame_x) + w > int'(regs.screen_width))
        w = int'(regs.screen_width) - int'(regs.frame_x);
      return w;
    endfunction

    function void emit(logic kind, logic [9:0] wx, logic [9:0] wy, logic [10:0] wlen,
                       logic [15:0] color);
      out_item_t d;
      d.kind = kind;
      d.window_x = wx;
      d.window_y = wy;
      d.window_length = wlen;
      d.pixel_color = color;
      d.last = 1'b0;
      expected_draws.push_back(d);
      emitted++;
    endfunction

    // Send the buffered run as a window followed by its pixels
    function void flush_run(logic [9:0] row);
      if (run_len == 0)
        return;
      emit(KIND_WINDOW, run_x, row, 11'(run_len), '0);
      for (int i = 0; i < run_len; i++)
        emit(KIND_PIXEL, '0, '0, '0, run_pixels[i]);
      run_len = 0;
    endfunction

    function void predict_draws(in_item_t it);
      int          p;
      int          w;
      bit          vis;
      bit          trans;
      logic [7:0]  idx;
      logic [15:0] color;
      out_item_t   tail;
      emitted = 0;
      if (it.operation == OP_PALETTE) begin
        palette[it.color_index] = it.palette_color;
        return;
      end
      p = line_pos;
      if (line_pos < int'(POS_MAX))
        line_pos++;
      w = visible_width();
      vis = (it.line_row < regs.screen_height) && (regs.frame_x < regs.screen_width) &&
            (w >= 1) && (p < w);
      idx = it.color_index;
      if (regs.disposal_restore && idx == regs.transparent_index)
        idx = regs.background_index;
      trans = regs.transparency_on && !regs.disposal_restore;
      if (vis) begin
        color = palette[idx];
        if (!trans) begin
          // Direct mode: drop any pending run, one window per line
          run_len = 0;
          if (!window_open) begin
            emit(KIND_WINDOW, regs.frame_x, it.line_row, 11'(w), '0);
            window_open = 1'b1;
          end
          emit(KIND_PIXEL, '0, '0, '0, color);
        end else begin
          if (idx == regs.transparent_index) begin
            flush_run(it.line_row);
          end else begin
            if (run_len == 0)
              run_x = 10'(int'(regs.frame_x) + p);
            if (run_len < RUN_DEPTH) begin
              run_pixels[run_len] = color;
              run_len++;
            end
            if (run_len >= RUN_DEPTH)
              flush_run(it.line_row);
          end
          if (p == w - 1)
            flush_run(it.line_row);
        end
      end
      if (it.line_end) begin
        flush_run(it.line_row);
        line_pos = 0;
        window_open = 1'b0;
        run_len = 0;
      end
      // Mark the final draw item caused by this pixel
      if (emitted > 0) begin
        tail = expected_draws.pop_back();
        tail.last = 1'b1;
        expected_draws.push_back(tail);
      end
    endfunction

    function void check_draw(out_item_t got);
      out_item_t want;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected draw item: kind=%0d x=%0d y=%0d len=%0d color=%h last=%0d",
                   got.kind, got.window_x, got.window_y, got.window_length,
                   got.pixel_color, got.last);
        return;
      end
      want = expected_draws.pop_front();
      draws_checked++;
      if (got.kind !== want.kind || got.window_x !== want.window_x ||
          got.window_y !== want.window_y || got.window_length !== want.window_length ||
          got.pixel_color !== want.pixel_color || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("draw item %0d mismatch", draws_checked);
          $display("  expected kind=%0d x=%0d y=%0d len=%0d color=%h last=%0d",
                   want.kind, want.window_x, want.window_y, want.window_length,
                   want.pixel_color, want.last);
          $display("  actual   kind=%0d x=%0d y=%0d len=%0d color=%h last=%0d",
                   got.kind, got.window_x, got.window_y, got.window_length,
                   got.pixel_color, got.last);
        end
      end
    endfunction
  endclass

  draw_scoreboard board = new();

  int         send_idle_pct = 27;
  int         recv_idle_pct = 46;
  int         stall_requests = 0;
  int         items_sent = 0;
  int         palette_writes = 0;
  int         input_stalls = 0;
  int         configs_used = 0;
  logic [7:0] known_slots[$];
  bit         slot_written [256];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one item, idling at random first, and note it once taken
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) begin
      input_stalls++;
      @(posedge clk);
    end
    board.predict_draws(it);
    items_sent++;
  endtask

  task automatic write_palette(input logic [7:0] slot, input logic [15:0] color);
    in_item_t it;
    it.operation = OP_PALETTE;
    it.color_index = slot;
    it.palette_color = color;
    it.line_row = 10'($urandom());
    it.line_end = 1'($urandom());
    send_item(it);
    palette_writes++;
    if (!slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      known_slots.push_back(slot);
    end
  endtask

  task automatic send_pixel(input logic [7:0] idx, input logic [9:0] row, input bit lend);
    in_item_t it;
    it.operation = OP_PIXEL;
    it.color_index = idx;
    it.palette_color = 16'($urandom());
    it.line_row = row;
    it.line_end = lend;
    send_item(it);
  endtask

  // Hold the input and wait until every owed draw item has come out
  task automatic settle();
    push <= 1'b0;
    while (board.expected_draws.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic apply_config(input cfg_t c);
    settle();
    write_reg(REG_FRAME_X, 11'(c.frame_x));
    write_reg(REG_IMAGE_WIDTH, c.image_width);
    write_reg(REG_TRANSPARENT_INDEX, 11'(c.transparent_index));
    write_reg(REG_BACKGROUND_INDEX, 11'(c.background_index));
    write_reg(REG_DISPOSAL_RESTORE, 11'(c.disposal_restore));
    write_reg(REG_TRANSPARENCY_ON, 11'(c.transparency_on));
    write_reg(REG_SCREEN_WIDTH, c.screen_width);
    write_reg(REG_SCREEN_HEIGHT, c.screen_height);
    cfg_valid <= 1'b0;
    configs_used++;
  endtask

  function automatic cfg_t make_config(int fx, int iw, logic [7:0] ti, logic [7:0] bi,
                                       bit dr, bit tr, int dw, int dh);
    cfg_t c;
    c.frame_x = 10'(fx);
    c.image_width = 11'(iw);
    c.transparent_index = ti;
    c.background_index = bi;
    c.disposal_restore = dr;
    c.transparency_on = tr;
    c.screen_width = 11'(dw);
    c.screen_height = 11'(dh);
    return c;
  endfunction

  function automatic logic [7:0] pick_slot();
    return known_slots[$urandom_range(known_slots.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_opaque();
    logic [7:0] s;
    do s = pick_slot(); while (s == board.regs.transparent_index);
    return s;
  endfunction

  // Random settings, leaning toward visible lines, with the extremes mixed in
  function automatic cfg_t pick_config();
    int dw;
    int fx;
    int iw;
    int dh;
    int r;
    r = $urandom_range(9);
    dw = (r == 0) ? 1 : (r == 1) ? 1024 : (r < 5) ? 320 : $urandom_range(1024, 48);
    r = $urandom_range(9);
    if (r == 0)
      fx = 1023;
    else if (r == 1)
      fx = $urandom_range(1023);
    else
      fx = $urandom_range((dw > 40) ? 40 : dw - 1);
    r = $urandom_range(9);
    iw = (r == 0) ? 1024 : (r == 1) ? 1 : $urandom_range(48, 2);
    r = $urandom_range(9);
    dh = (r == 0) ? 1 : (r == 1) ? 1024 : $urandom_range(1024, 2);
    return make_config(fx, iw, pick_slot(), pick_slot(), $urandom_range(3) == 0,
                       $urandom_range(3) != 0, dw, dh);
  endfunction

  // One line of pixels with palette updates sprinkled in; solid lines have no holes
  task automatic run_line(input int len, input logic [9:0] row, input bit solid);
    int         i;
    logic [7:0] idx;
    logic [9:0] r;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8)
        write_palette(8'($urandom()), 16'($urandom()));
      if (!solid && $urandom_range(99) < 25)
        idx = board.regs.transparent_index;
      else
        idx = pick_opaque();
      r = ($urandom_range(99) < 5) ? 10'($urandom()) : row;
      send_pixel(idx, r, i == len - 1);
    end
  endtask

  task automatic random_phase(input int target, input bit pressure);
    cfg_t       c;
    int         first;
    int         w;
    int         cap;
    int         len;
    int         top_row;
    bit         solid;
    logic [9:0] row;
    if (pressure)
      c = make_config(0, 64, pick_slot(), pick_slot(), 1'b0, 1'b0, 1024, 1024);
    else
      c = pick_config();
    apply_config(c);
    // Let the sink hold off while lines keep coming, so the input backs up
    if (pressure)
      stall_requests <= stall_requests + 1;
    first = items_sent;
    while (items_sent - first < target) begin
      w = board.visible_width();
      cap = (w < 1) ? 8 : (w > 40) ? 40 : w;
      solid = ($urandom_range(9) < 3);
      if (solid && w >= 33)
        len = $urandom_range(40, 33);
      else
        len = $urandom_range(cap + 3, 1);
      top_row = int'(c.screen_height) - 1;
      if (top_row > 1023)
        top_row = 1023;
      row = ($urandom_range(99) < 85) ? 10'($urandom_range(top_row)) : 10'($urandom());
      run_line(len, row, solid);
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Direct mode, a full line on the bottom row, then a row past the display
    apply_config(make_config(0, 4, 8'hA5, 8'hFF, 1'b0, 1'b0, 320, 240));
    write_palette(8'h00, 16'h0000);
    write_palette(8'hFF, 16'hFFFF);
    write_palette(8'h5A, 16'hA5C3);
    write_palette(8'hA5, 16'h5A3C);
    send_pixel(8'h00, 10'd239, 1'b0);
    send_pixel(8'hFF, 10'd239, 1'b0);
    send_pixel(8'h5A, 10'd239, 1'b0);
    send_pixel(8'hA5, 10'd239, 1'b1);
    send_pixel(8'h00, 10'd240, 1'b1);

    // Frame at the right edge: one visible column, cropped pixels, transparent pixel
    apply_config(make_config(1023, 1024, 8'h00, 8'h00, 1'b0, 1'b1, 1024, 1024));
    send_pixel(8'hFF, 10'd1023, 1'b0);
    send_pixel(8'h5A, 10'd1023, 1'b1);
    send_pixel(8'h00, 10'd1023, 1'b1);

    // Opaque runs split by a transparent pixel, flushed at line end
    apply_config(make_config(2, 40, 8'h00, 8'hFF, 1'b0, 1'b1, 1024, 1024));
    send_pixel(8'hFF, 10'h2AA, 1'b0);
    send_pixel(8'h5A, 10'h2AA, 1'b0);
    send_pixel(8'hA5, 10'h2AA, 1'b0);
    send_pixel(8'h00, 10'h2AA, 1'b0);
    send_pixel(8'hFF, 10'h2AA, 1'b0);
    send_pixel(8'hA5, 10'h2AA, 1'b1);

    // Leave a run pending, then drop transparency mid-line and switch to restore
    apply_config(make_config(0, 16, 8'h00, 8'hFF, 1'b0, 1'b1, 320, 240));
    send_pixel(8'hFF, 10'd5, 1'b0);
    send_pixel(8'h5A, 10'd5, 1'b0);
    apply_config(make_config(0, 16, 8'h00, 8'hFF, 1'b0, 1'b0, 320, 240));
    send_pixel(8'hA5, 10'd5, 1'b0);
    apply_config(make_config(0, 16, 8'h5A, 8'hFF, 1'b1, 1'b1, 320, 240));
    send_pixel(8'h5A, 10'd5, 1'b0);
    send_pixel(8'h00, 10'd5, 1'b1);

    // Frame origin beyond the display width drops the line
    apply_config(make_config(500, 8, 8'h00, 8'h00, 1'b0, 1'b0, 400, 1024));
    send_pixel(8'hFF, 10'd0, 1'b1);

    // Burst on a one-pixel-wide line; only the first pixel is visible
    apply_config(make_config(0, 1, 8'h00, 8'h00, 1'b0, 1'b0, 1024, 1024));
    for (i = 0; i < BURST_PIXELS; i++)
      send_pixel(pick_slot(), 10'd7, 1'b0);
    send_pixel(pick_slot(), 10'd7, 1'b1);

    // Random lines: sender idles less than receiver, then the reverse, then none
    random_phase(12, 1'b0);
    random_phase(12, 1'b0);
    send_idle_pct = 46;
    recv_idle_pct = 27;
    random_phase(12, 1'b0);
    random_phase(12, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(18, 1'b1);
    random_phase(12, 1'b0);

    settle();
    $display("covered %0d items (%0d palette writes) over %0d register settings",
             items_sent, palette_writes, configs_used);
    $display("checked %0d draw items; input held back by full for %0d cycles",
             board.draws_checked, input_stalls);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  // Drain draw items, with random idling and an occasional long hold-off
  initial begin : draw_sink
    int hold_left;
    int stalls_seen;
    hold_left = 0;
    stalls_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        board.check_draw(result);
      if (stall_requests != stalls_seen) begin
        stalls_seen = stall_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(8 * 400000);
    $display("timeout with %0d draw items still owed", board.expected_draws.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/glpc_pkg.sv
rtl/glpc_queue.sv
rtl/glpc_front.sv
rtl/glpc_back.sv
rtl/gif_line_palette_compositor.sv
tb/tb.sv
